FILE: sv/kti_pkg.sv
// ----------------------------------------------------------------------------
// kti_pkg
// Shared types, constants and helper functions for the key to token and
// initial sequence number hash pipeline.
// ----------------------------------------------------------------------------
package kti_pkg;

  localparam int unsigned KeyWidth   = 64;
  localparam int unsigned TokenWidth = 32;
  localparam int unsigned SeqWidth   = 64;
  localparam int unsigned InWidth    = 64;
  localparam int unsigned OutWidth   = 96;
  localparam int unsigned NumRounds  = 80;
  localparam int unsigned WinWords   = 16;

  localparam logic [31:0] H0Init = 32'h67452301;
  localparam logic [31:0] H1Init = 32'hEFCDAB89;
  localparam logic [31:0] H2Init = 32'h98BADCFE;
  localparam logic [31:0] H3Init = 32'h10325476;
  localparam logic [31:0] H4Init = 32'hC3D2E1F0;

  localparam logic [31:0] PadWord = 32'h80000000;
  localparam logic [31:0] LenWord = 32'd64;

  typedef enum logic [1:0] {
    PH_CHOOSE,
    PH_PARITY1,
    PH_MAJORITY,
    PH_PARITY2
  } phase_e;

  // Working variables plus the sixteen-word message schedule window.
  typedef struct packed {
    logic [31:0]                 a;
    logic [31:0]                 b;
    logic [31:0]                 c;
    logic [31:0]                 d;
    logic [31:0]                 e;
    logic [WinWords-1:0][31:0]   w;
  } round_st_t;

  typedef struct packed {
    logic [TokenWidth-1:0] session_token;
    logic [SeqWidth-1:0]   initial_seq;
  } result_t;

  function automatic logic [31:0] rotl1(input logic [31:0] v);
    return {v[30:0], v[31]};
  endfunction

  function automatic logic [31:0] rotl5(input logic [31:0] v);
    return {v[26:0], v[31:27]};
  endfunction

  function automatic logic [31:0] rotl30(input logic [31:0] v);
    return {v[1:0], v[31:2]};
  endfunction

  function automatic logic [31:0] bswap32(input logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

  function automatic phase_e phase_of(input int unsigned round);
    if (round < 20) begin
      return PH_CHOOSE;
    end else if (round < 40) begin
      return PH_PARITY1;
    end else if (round < 60) begin
      return PH_MAJORITY;
    end
    return PH_PARITY2;
  endfunction

endpackage

FILE: sv/kti_round.sv
// ----------------------------------------------------------------------------
// kti_round
// One registered SHA-1 round: updates the working variables and slides the
// message schedule window by one word.
// ----------------------------------------------------------------------------
module kti_round (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  kti_pkg::phase_e    phase_i,
  input  logic               valid_i,
  input  kti_pkg::round_st_t st_i,
  output logic               valid_o,
  output kti_pkg::round_st_t st_o
);
  import kti_pkg::*;

  logic        valid_q;
  round_st_t   st_q;
  round_st_t   st_d;
  logic [31:0] f;
  logic [31:0] k;
  logic [31:0] w_new;

  always_comb begin
    unique case (phase_i)
      PH_CHOOSE: begin
        f = (st_i.b & st_i.c) | (~st_i.b & st_i.d);
        k = 32'h5A827999;
      end
      PH_PARITY1: begin
        f = st_i.b ^ st_i.c ^ st_i.d;
        k = 32'h6ED9EBA1;
      end
      PH_MAJORITY: begin
        f = (st_i.b & st_i.c) | (st_i.b & st_i.d) | (st_i.c & st_i.d);
        k = 32'h8F1BBCDC;
      end
      PH_PARITY2: begin
        f = st_i.b ^ st_i.c ^ st_i.d;
        k = 32'hCA62C1D6;
      end
      default: begin
        f = '0;
        k = '0;
      end
    endcase
  end

  // The window always holds words i..i+15, so the word used is the oldest
  // one and the word appended is the schedule word i+16.
  assign w_new = rotl1(st_i.w[13] ^ st_i.w[8] ^ st_i.w[2] ^ st_i.w[0]);

  always_comb begin
    st_d   = st_i;
    st_d.a = rotl5(st_i.a) + f + st_i.e + k + st_i.w[0];
    st_d.b = st_i.a;
    st_d.c = rotl30(st_i.b);
    st_d.d = st_i.c;
    st_d.e = st_i.d;
    for (int j = 0; j < WinWords - 1; j++) begin
      st_d.w[j] = st_i.w[j+1];
    end
    st_d.w[WinWords-1] = w_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q <= st_d;
    end
  end

  assign valid_o = valid_q;
  assign st_o    = st_q;

endmodule

FILE: sv/kti_skid.sv
// ----------------------------------------------------------------------------
// kti_skid
// Two-entry output buffer that finishes the digest and decouples the round
// pipeline from the downstream ready.
// ----------------------------------------------------------------------------
module kti_skid (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  kti_pkg::round_st_t st_i,
  output logic               en_o,
  output logic               valid_o,
  input  logic               ready_i,
  output kti_pkg::result_t   res_o
);
  import kti_pkg::*;

  logic [1:0]  count_q;
  logic [1:0]  count_d;
  result_t     slot0_q;
  result_t     slot1_q;
  result_t     res_d;
  logic [31:0] h0;
  logic [31:0] h3;
  logic [31:0] h4;
  logic        push;
  logic        pop;

  // Only the digest words that feed the two result fields are formed.
  assign h0 = H0Init + st_i.a;
  assign h3 = H3Init + st_i.d;
  assign h4 = H4Init + st_i.e;

  assign res_d.session_token = bswap32(h0);
  assign res_d.initial_seq   = {h3, h4};

  assign en_o    = (count_q != 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign push    = en_o & valid_i;
  assign pop     = valid_o & ready_i;

  always_comb begin
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (push && count_q == 2'd1) begin
        slot0_q <= res_d;
      end else begin
        slot0_q <= slot1_q;
      end
      if (push && count_q == 2'd2) begin
        slot1_q <= res_d;
      end
    end else if (push) begin
      if (count_q == 2'd0) begin
        slot0_q <= res_d;
      end else begin
        slot1_q <= res_d;
      end
    end
  end

  assign res_o = slot0_q;

endmodule

FILE: sv/key_to_token_and_idsn.sv
// ----------------------------------------------------------------------------
// key_to_token_and_idsn
// Session token and initial data sequence number from a 64-bit connection
// key by a single-block SHA-1 hash, one round per pipeline stage.
// ----------------------------------------------------------------------------
// A key accepted at the input passes the 80 round stage registers and then the output
// buffer register before its result is on the output.
// Throughput: one key per cycle while the output buffer is not full, set by the
// 80 registered round stages.
// The two-entry output buffer keeps the input open while one result waits.
// Reset clears all valid bits and the buffer count; data registers hold.
module key_to_token_and_idsn (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [63:0] conn_key
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata    // [31:0] session_token, [95:32] initial_seq
);
  import kti_pkg::*;

  logic                      en;
  logic [NumRounds:0]        valid;
  round_st_t [NumRounds:0]   st;
  result_t                   res;

  // Key bytes go in least significant first, so each half is byte swapped
  // into a big-endian message word; the rest is the fixed padding.
  always_comb begin
    st[0].a = H0Init;
    st[0].b = H1Init;
    st[0].c = H2Init;
    st[0].d = H3Init;
    st[0].e = H4Init;
    st[0].w = '0;
    st[0].w[0] = bswap32(s_axis_tdata[31:0]);
    st[0].w[1] = bswap32(s_axis_tdata[63:32]);
    st[0].w[2] = PadWord;
    st[0].w[WinWords-1] = LenWord;
  end

  assign valid[0]      = s_axis_tvalid;
  assign s_axis_tready = en;

  for (genvar r = 0; r < NumRounds; r++) begin : g_round
    kti_round u_round (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .phase_i (phase_of(r)),
      .valid_i (valid[r]),
      .st_i    (st[r]),
      .valid_o (valid[r+1]),
      .st_o    (st[r+1])
    );
  end

  kti_skid u_skid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid[NumRounds]),
    .st_i    (st[NumRounds]),
    .en_o    (en),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (res)
  );

  assign m_axis_tdata = {res.initial_seq, res.session_token};

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the key to token and initial sequence number hash.
// Keys are streamed in with random gaps and results are drained with random
// back-pressure. Each accepted key is hashed by a local SHA-1 computation and
// the token and sequence number are compared in order with the block output.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import kti_pkg::*;

  localparam int unsigned NumRandomKeys = 1250;
  localparam int unsigned CycleLimit    = 200000;
  localparam int unsigned DrainCycles   = 120;
  localparam int unsigned IdlePercent   = 32;
  // Both sides run without gaps or stalls for this stretch of traffic.
  localparam int unsigned CalmFirst     = 500;
  localparam int unsigned CalmLast      = 800;

  typedef struct {
    logic [TokenWidth-1:0] session_token;
    logic [SeqWidth-1:0]   initial_seq;
  } token_seq_t;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [KeyWidth-1:0] s_axis_tdata = '0;  // [63:0] conn_key
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [OutWidth-1:0] m_axis_tdata;       // [31:0] session_token, [95:32] initial_seq

  logic [KeyWidth-1:0] pending_keys[$];
  token_seq_t          expected_results[$];
  int unsigned         keys_sent    = 0;
  int unsigned         results_seen = 0;
  int unsigned         error_count  = 0;
  int unsigned         cycle_count  = 0;

  key_to_token_and_idsn DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #6 clk_i = ~clk_i;

  // Single-block SHA-1 of the key bytes, least significant byte first.
  function automatic token_seq_t hash_conn_key(input logic [KeyWidth-1:0] key);
    logic [31:0] w[16];
    logic [31:0] a, b, c, d, e, f, k, t, wi, x;
    logic [31:0] h0, h1, h2, h3, h4;
    token_seq_t  res;
    w[0] = {key[7:0], key[15:8], key[23:16], key[31:24]};
    w[1] = {key[39:32], key[47:40], key[55:48], key[63:56]};
    w[2] = 32'h8000_0000;
    for (int i = 3; i < 15; i++) begin
      w[i] = '0;
    end
    w[15] = 32'd64;
    h0 = 32'h6745_2301;
    h1 = 32'hEFCD_AB89;
    h2 = 32'h98BA_DCFE;
    h3 = 32'h1032_5476;
    h4 = 32'hC3D2_E1F0;
    a = h0; b = h1; c = h2; d = h3; e = h4;
    for (int i = 0; i < 80; i++) begin
      if (i < 16) begin
        wi = w[i];
      end else begin
        x  = w[(i + 13) % 16] ^ w[(i + 8) % 16] ^ w[(i + 2) % 16] ^ w[i % 16];
        wi = {x[30:0], x[31]};
        w[i % 16] = wi;
      end
      if (i < 20) begin
        f = (b & c) | (~b & d);
        k = 32'h5A82_7999;
      end else if (i < 40) begin
        f = b ^ c ^ d;
        k = 32'h6ED9_EBA1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = 32'h8F1B_BCDC;
      end else begin
        f = b ^ c ^ d;
        k = 32'hCA62_C1D6;
      end
      t = {a[26:0], a[31:27]} + f + e + k + wi;
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = t;
    end
    h0 += a; h3 += d; h4 += e;
    // Token is digest bytes 0..3 little-endian; sequence is bytes 12..19 big-endian.
    res.session_token = {h0[7:0], h0[15:8], h0[23:16], h0[31:24]};
    res.initial_seq   = {h3, h4};
    return res;
  endfunction

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Key driver: a request stays up until it is taken, then the next one may follow.
  always @(posedge clk_i) begin
    logic calm;
    calm = (keys_sent >= CalmFirst) && (keys_sent < CalmLast);
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(hash_conn_key(s_axis_tdata));
        keys_sent <= keys_sent + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_keys.size() > 0 && (calm || $urandom_range(99) >= IdlePercent)) begin
          s_axis_tdata  <= pending_keys.pop_front();
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ((results_seen >= CalmFirst) && (results_seen < CalmLast)) ||
                     ($urandom_range(99) >= IdlePercent);
  end

  // Result monitor: in-order compare against the oldest expectation.
  always @(posedge clk_i) begin
    token_seq_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen <= results_seen + 1;
      if (expected_results.size() == 0) begin
        $error("unexpected result: session_token %h initial_seq %h",
               m_axis_tdata[31:0], m_axis_tdata[95:32]);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (m_axis_tdata[31:0] !== want.session_token) begin
          $error("session_token mismatch: expected %h, actual %h",
                 want.session_token, m_axis_tdata[31:0]);
          error_count++;
        end
        if (m_axis_tdata[95:32] !== want.initial_seq) begin
          $error("initial_seq mismatch: expected %h, actual %h",
                 want.initial_seq, m_axis_tdata[95:32]);
          error_count++;
        end
      end
    end
  end

  initial begin
    logic [KeyWidth-1:0] key;
    int unsigned         pick;
    // Directed keys: extremes, single bits, byte order and alternating patterns.
    pending_keys.push_back(64'h0000_0000_0000_0000);
    pending_keys.push_back(64'hFFFF_FFFF_FFFF_FFFF);
    pending_keys.push_back(64'h0000_0000_0000_0001);
    pending_keys.push_back(64'h8000_0000_0000_0000);
    pending_keys.push_back(64'h0000_0000_FFFF_FFFF);
    pending_keys.push_back(64'hFFFF_FFFF_0000_0000);
    pending_keys.push_back(64'hAAAA_AAAA_AAAA_AAAA);
    pending_keys.push_back(64'h5555_5555_5555_5555);
    pending_keys.push_back(64'h0123_4567_89AB_CDEF);
    pending_keys.push_back(64'hFEDC_BA98_7654_3210);
    pending_keys.push_back(64'h0000_0000_8000_0000);
    pending_keys.push_back(64'h0000_0001_0000_0000);
    pending_keys.push_back(64'h0000_0000_0000_00FF);
    pending_keys.push_back(64'hFF00_0000_0000_0000);
    pending_keys.push_back(64'h7FFF_FFFF_FFFF_FFFF);
    pending_keys.push_back(64'hDEAD_BEEF_CAFE_F00D);
    // The same key twice in a row must give the same result twice.
    pending_keys.push_back(64'hDEAD_BEEF_CAFE_F00D);
    for (int n = 0; n < NumRandomKeys; n++) begin
      pick = $urandom_range(99);
      key  = {$urandom(), $urandom()};
      if (pick < 10) begin
        key = 64'd1 << $urandom_range(63);
      end else if (pick < 20) begin
        key = ~(64'd1 << $urandom_range(63));
      end else if (pick < 30) begin
        key = 64'(key[7:0]) << (8 * $urandom_range(7));
      end
      pending_keys.push_back(key);
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_keys.size() > 0 || s_axis_tvalid || expected_results.size() > 0) begin
      @(posedge clk_i);
    end
    // Let any stray result surface before the verdict.
    repeat (DrainCycles) @(posedge clk_i);

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/kti_pkg.sv
sv/kti_round.sv
sv/kti_skid.sv
sv/key_to_token_and_idsn.sv
tb/tb.sv
